@@ hw/rtl/ray_capped_cylinder_intersect_top_assert.svh @@
// assertion macros for the capped cylinder intersection block
// expects clk and rst_n in the scope of the module that uses them
`ifndef RAY_CAPPED_CYLINDER_INTERSECT_TOP_ASSERT_SVH
`define RAY_CAPPED_CYLINDER_INTERSECT_TOP_ASSERT_SVH

// same-cycle implication
`define RCCI_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCCI_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rcci_pkg.sv @@
// types, constants and saturating q16.16 arithmetic for the cylinder intersector
// no dependencies
`default_nettype none

package rcci_pkg;

  localparam int unsigned CW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned NW = FB + 2;
  localparam int unsigned XW = CW + FB;
  localparam int unsigned DIV_STEPS = CW + FB;
  localparam int unsigned DIV_LAT = DIV_STEPS + 2;
  localparam int unsigned SQRT_STEPS = (CW + FB) / 2;
  localparam int unsigned RW = CW - 1;

  typedef logic signed [CW-1:0] q_t;
  typedef logic signed [NW-1:0] nrm_t;

  localparam q_t QMAX = q_t'({1'b0, {(CW-1){1'b1}}});
  localparam q_t QMIN = q_t'({1'b1, {(CW-1){1'b0}}});
  localparam q_t QONE = q_t'(1 << FB);
  localparam nrm_t NONE = nrm_t'(1 << FB);

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_RADIUS,
    REG_HEIGHT
  } reg_idx_t;

  typedef enum logic [2:0] {
    W_NONE,
    W_SIDE1,
    W_SIDE2,
    W_BOT,
    W_TOP
  } win_kind_t;

  typedef struct packed {
    q_t ox;
    q_t oy;
    q_t oz;
    q_t dx;
    q_t dy;
    q_t dz;
    q_t tmin;
    q_t tmax;
  } ray_t;

  typedef struct packed {
    q_t   a;
    q_t   nhb;
    logic en;
  } side_t;

  typedef struct packed {
    q_t t;
    q_t px;
    q_t py;
    q_t pz;
  } cand_t;

  typedef struct packed {
    win_kind_t kind;
    cand_t     c;
  } win_t;

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [CW:0] s;
    s = $signed({a[CW-1], a}) + $signed({b[CW-1], b});
    if (s[CW] != s[CW-1]) return s[CW] ? QMIN : QMAX;
    return s[CW-1:0];
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [CW:0] s;
    s = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    if (s[CW] != s[CW-1]) return s[CW] ? QMIN : QMAX;
    return s[CW-1:0];
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [2*CW-1:0]    p;
    logic signed [2*CW-FB-1:0] s;
    p = $signed({{CW{a[CW-1]}}, a}) * $signed({{CW{b[CW-1]}}, b});
    s = p[2*CW-1:FB];
    if ((&s[2*CW-FB-1:CW-1]) || !(|s[2*CW-FB-1:CW-1])) return s[CW-1:0];
    return s[2*CW-FB-1] ? QMIN : QMAX;
  endfunction

  function automatic nrm_t unit_clamp(input q_t v);
    if (v > QONE) return NONE;
    if (v < -QONE) return -NONE;
    return v[NW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rcci_div.sv @@
// pipelined signed q16.16 divider, one quotient bit per stage, saturating
// depends on rcci_pkg
`default_nettype none

module rcci_div
  import rcci_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  q_t   num,
  input  q_t   den,
  output q_t   quo
);

  typedef struct packed {
    logic neg;
    logic dzero;
    logic npos;
    logic nneg;
  } dflag_t;

  logic [CW-1:0] rem_r [0:DIV_STEPS];
  logic [XW-1:0] nq_r  [0:DIV_STEPS];
  logic [CW-1:0] dm_r  [0:DIV_STEPS];
  dflag_t        fl_r  [0:DIV_STEPS];
  logic [CW-1:0] rem_nxt [1:DIV_STEPS];
  logic [XW-1:0] nq_nxt  [1:DIV_STEPS];
  logic [CW:0]   nmag;
  logic [CW:0]   dmag;
  logic signed [XW:0] sq;
  q_t            quo_r;
  q_t            quo_nxt;

  assign nmag = num[CW-1] ? -{num[CW-1], num} : {num[CW-1], num};
  assign dmag = den[CW-1] ? -{den[CW-1], den} : {den[CW-1], den};

  always_comb begin
    logic [CW:0] t;
    for (int i = 1; i <= DIV_STEPS; i++) begin
      t = {rem_r[i-1], nq_r[i-1][XW-1]};
      if (t >= {1'b0, dm_r[i-1]}) begin
        rem_nxt[i] = CW'(t - {1'b0, dm_r[i-1]});
        nq_nxt[i]  = {nq_r[i-1][XW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = t[CW-1:0];
        nq_nxt[i]  = {nq_r[i-1][XW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sq = fl_r[DIV_STEPS].neg ? -$signed({1'b0, nq_r[DIV_STEPS]})
                             : $signed({1'b0, nq_r[DIV_STEPS]});
    if (fl_r[DIV_STEPS].dzero) begin
      quo_nxt = fl_r[DIV_STEPS].npos ? QMAX : (fl_r[DIV_STEPS].nneg ? QMIN : '0);
    end else if ((&sq[XW:CW-1]) || !(|sq[XW:CW-1])) begin
      quo_nxt = sq[CW-1:0];
    end else begin
      quo_nxt = sq[XW] ? QMIN : QMAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= {nmag[CW-1:0], {FB{1'b0}}};
      dm_r[0]  <= dmag[CW-1:0];
      fl_r[0]  <= '{neg: num[CW-1] ^ den[CW-1], dzero: (den == '0),
                    npos: (!num[CW-1] && num != '0), nneg: num[CW-1]};
      for (int i = 1; i <= DIV_STEPS; i++) begin
        rem_r[i] <= rem_nxt[i];
        nq_r[i]  <= nq_nxt[i];
        dm_r[i]  <= dm_r[i-1];
        fl_r[i]  <= fl_r[i-1];
      end
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

@@ hw/rtl/ray_capped_cylinder_intersect_top.sv @@
// ray against a capped z-aligned cylinder, signed q16.16, fully pipelined
// depends on rcci_pkg, rcci_div and ray_capped_cylinder_intersect_top_assert.svh
//
// usage: rays enter on the in_ channel (valid/stall), one transaction per cycle
// at most; each ray gives exactly one result transaction on the out_ channel,
// in order. throughput is one ray per cycle while out_stall does not hold the
// pipeline. the depth is set by the square root (24 stages) and two dividers
// in series of 50 stages each (one quotient bit per stage).
// the cylinder is set through the apb port: centre x, y, bottom z, radius and
// height at byte addresses 0, 4, 8, 12, 16; writes must go only while the
// pipeline is empty, which the block does not enforce. reset clears every
// valid bit and loads centre 0, radius and height 1.0. when out_stall is high
// with a result waiting, the whole pipeline holds and in_stall rises in the
// same cycle; nothing is dropped or repeated. a miss returns all fields zero.
`default_nettype none

module ray_capped_cylinder_intersect_top
  import rcci_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [CW-1:0] pwdata,
  output logic [CW-1:0] prdata,
  output logic          pready,
  input  logic          in_valid,
  output logic          in_stall,
  input  q_t            in_ray_origin_x,
  input  q_t            in_ray_origin_y,
  input  q_t            in_ray_origin_z,
  input  q_t            in_ray_dir_x,
  input  q_t            in_ray_dir_y,
  input  q_t            in_ray_dir_z,
  input  q_t            in_t_lower,
  input  q_t            in_t_upper,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_hit_found,
  output q_t            out_hit_t,
  output q_t            out_point_x,
  output q_t            out_point_y,
  output q_t            out_point_z,
  output nrm_t          out_normal_x,
  output nrm_t          out_normal_y,
  output nrm_t          out_normal_z,
  output logic          out_front_face
);

  `include "ray_capped_cylinder_intersect_top_assert.svh"

  localparam int unsigned S_SQ0 = 7;
  localparam int unsigned S_DIN = S_SQ0 + SQRT_STEPS;
  localparam int unsigned S_RT  = S_DIN + DIV_LAT;
  localparam int unsigned S_NRM = S_RT + 8;
  localparam int unsigned S_NQ  = S_NRM + DIV_LAT;
  localparam int unsigned LAST  = S_NQ + 2;

  // configuration
  q_t          cfg_cx_r, cfg_cy_r, cfg_cz_r;
  logic [RW-1:0] cfg_rad_r, cfg_hgt_r;
  q_t          rr_r, ctop_r, rad_q, hgt_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign rad_q  = $signed({1'b0, cfg_rad_r});
  assign hgt_q  = $signed({1'b0, cfg_hgt_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cx_r  <= '0;
      cfg_cy_r  <= '0;
      cfg_cz_r  <= '0;
      cfg_rad_r <= RW'(1 << FB);
      cfg_hgt_r <= RW'(1 << FB);
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_CENTER_X: cfg_cx_r  <= pwdata;
        REG_CENTER_Y: cfg_cy_r  <= pwdata;
        REG_CENTER_Z: cfg_cz_r  <= pwdata;
        REG_RADIUS:   cfg_rad_r <= pwdata[RW-1:0];
        REG_HEIGHT:   cfg_hgt_r <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CENTER_X: prdata = cfg_cx_r;
      REG_CENTER_Y: prdata = cfg_cy_r;
      REG_CENTER_Z: prdata = cfg_cz_r;
      REG_RADIUS:   prdata = {1'b0, cfg_rad_r};
      REG_HEIGHT:   prdata = {1'b0, cfg_hgt_r};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rr_r   <= qmul(rad_q, rad_q);
    ctop_r <= qadd(cfg_cz_r, hgt_q);
  end

  // pipeline control
  logic [LAST:0] vld_r;
  logic          adv;

  assign adv       = !vld_r[LAST] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  // payload stages
  ray_t  ray_r [0:LAST-1];
  q_t    ocx1_r, ocy1_r, mdx1_r, mdy1_r;
  q_t    a2_r, pxd2_r, pyd2_r, pxx2_r, pyy2_r;
  q_t    a3_r, hb3_r, cp3_r;
  q_t    a4_r, hb4_r, c4_r;
  q_t    a5_r, hb5_r, hh5_r, ac5_r;
  q_t    disc_nxt, disc6_r;
  side_t sd_r [S_SQ0-1:S_DIN-1];
  logic [XW-1:0] sq_x_r [0:SQRT_STEPS-1];
  logic [XW-1:0] sq_res_r [0:SQRT_STEPS-1];
  logic [XW-1:0] sq_xi [0:SQRT_STEPS-1];
  logic [XW-1:0] sq_ri [0:SQRT_STEPS-1];
  logic [XW-1:0] sq_x_nxt [0:SQRT_STEPS-1];
  logic [XW-1:0] sq_res_nxt [0:SQRT_STEPS-1];
  q_t    sroot;
  q_t    n1_r, n2_r, nb_r, nt_r, a31_r;
  logic  sen_r [S_DIN:S_RT+2];
  q_t    quo [0:3];
  cand_t c82_r [0:3];
  cand_t c83_r [0:3];
  cand_t c84_r [0:3];
  cand_t c85_r [0:3];
  cand_t c86_r [0:3];
  cand_t c87_r [0:1];
  logic  sok84_r [0:1];
  logic  sok85_r [0:1];
  logic  sok86_r [0:1];
  logic  cok86_r [0:1];
  logic  cok87_r [0:1];
  q_t    ddx84_r [0:1];
  q_t    ddy84_r [0:1];
  q_t    sqx85_r [0:1];
  q_t    sqy85_r [0:1];
  win_t  sel87_nxt, sel87_r;
  q_t    cl87_nxt, cl87_r;
  win_t  win_nxt;
  win_t  win_r [S_RT+7:S_NQ+1];
  q_t    nnx_r, nny_r, nxq, nyq;
  q_t    mx_r, my_r;
  nrm_t  cnx_r, cny_r;

  always_comb begin
    disc_nxt = qsub(hh5_r, ac5_r);
  end

  // square root, one result bit per stage
  always_comb begin
    logic [XW:0]   trial;
    logic [XW-1:0] bitv;
    sq_xi[0] = disc6_r[CW-1] ? '0 : {1'b0, disc6_r[CW-2:0], {FB{1'b0}}};
    sq_ri[0] = '0;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      sq_xi[j] = sq_x_r[j-1];
      sq_ri[j] = sq_res_r[j-1];
    end
    for (int j = 0; j < SQRT_STEPS; j++) begin
      bitv  = XW'(1) << (2 * (SQRT_STEPS - 1 - j));
      trial = {1'b0, sq_ri[j]} + {1'b0, bitv};
      if ({1'b0, sq_xi[j]} >= trial) begin
        sq_x_nxt[j]   = sq_xi[j] - trial[XW-1:0];
        sq_res_nxt[j] = (sq_ri[j] >> 1) + bitv;
      end else begin
        sq_x_nxt[j]   = sq_xi[j];
        sq_res_nxt[j] = sq_ri[j] >> 1;
      end
    end
  end

  assign sroot = $signed(sq_res_r[SQRT_STEPS-1][CW-1:0]);

  // side roots and cap planes
  rcci_div u_div_r1 (.clk(clk), .en(adv), .num(n1_r), .den(a31_r),
                     .quo(quo[0]));
  rcci_div u_div_r2 (.clk(clk), .en(adv), .num(n2_r), .den(a31_r),
                     .quo(quo[1]));
  rcci_div u_div_cb (.clk(clk), .en(adv), .num(nb_r), .den(ray_r[S_DIN].dz),
                     .quo(quo[2]));
  rcci_div u_div_ct (.clk(clk), .en(adv), .num(nt_r), .den(ray_r[S_DIN].dz),
                     .quo(quo[3]));

  // side normal
  rcci_div u_div_nx (.clk(clk), .en(adv), .num(nnx_r), .den(rad_q), .quo(nxq));
  rcci_div u_div_ny (.clk(clk), .en(adv), .num(nny_r), .den(rad_q), .quo(nyq));

  // closest candidate in model order: side roots, bottom cap, top cap
  always_comb begin
    q_t   tmn, cl1;
    logic k1, k2, kb, kt;
    q_t   clb;
    tmn = ray_r[S_RT+5].tmin;
    k1  = sok86_r[0] && c86_r[0].t >= tmn && c86_r[0].t < ray_r[S_RT+5].tmax;
    cl1 = k1 ? c86_r[0].t : ray_r[S_RT+5].tmax;
    k2  = sok86_r[1] && c86_r[1].t >= tmn && c86_r[1].t < cl1;
    if (k2) begin
      sel87_nxt = '{kind: W_SIDE2, c: c86_r[1]};
      cl87_nxt  = c86_r[1].t;
    end else if (k1) begin
      sel87_nxt = '{kind: W_SIDE1, c: c86_r[0]};
      cl87_nxt  = cl1;
    end else begin
      sel87_nxt = '{kind: W_NONE, c: '0};
      cl87_nxt  = cl1;
    end
    tmn = ray_r[S_RT+6].tmin;
    kb  = cok87_r[0] && c87_r[0].t >= tmn && c87_r[0].t < cl87_r;
    clb = kb ? c87_r[0].t : cl87_r;
    kt  = cok87_r[1] && c87_r[1].t >= tmn && c87_r[1].t < clb;
    if (kt) begin
      win_nxt = '{kind: W_TOP, c: c87_r[1]};
    end else if (kb) begin
      win_nxt = '{kind: W_BOT, c: c87_r[0]};
    end else begin
      win_nxt = sel87_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ray_r[0] <= '{ox: in_ray_origin_x, oy: in_ray_origin_y, oz: in_ray_origin_z,
                    dx: in_ray_dir_x, dy: in_ray_dir_y, dz: in_ray_dir_z,
                    tmin: in_t_lower, tmax: in_t_upper};
      for (int k = 1; k < LAST; k++) begin
        ray_r[k] <= ray_r[k-1];
      end

      ocx1_r <= qsub(ray_r[0].ox, cfg_cx_r);
      ocy1_r <= qsub(ray_r[0].oy, cfg_cy_r);
      mdx1_r <= qmul(ray_r[0].dx, ray_r[0].dx);
      mdy1_r <= qmul(ray_r[0].dy, ray_r[0].dy);

      a2_r   <= qadd(mdx1_r, mdy1_r);
      pxd2_r <= qmul(ocx1_r, ray_r[1].dx);
      pyd2_r <= qmul(ocy1_r, ray_r[1].dy);
      pxx2_r <= qmul(ocx1_r, ocx1_r);
      pyy2_r <= qmul(ocy1_r, ocy1_r);

      a3_r  <= a2_r;
      hb3_r <= qadd(pxd2_r, pyd2_r);
      cp3_r <= qadd(pxx2_r, pyy2_r);

      a4_r  <= a3_r;
      hb4_r <= hb3_r;
      c4_r  <= qsub(cp3_r, rr_r);

      a5_r  <= a4_r;
      hb5_r <= hb4_r;
      hh5_r <= qmul(hb4_r, hb4_r);
      ac5_r <= qmul(a4_r, c4_r);

      disc6_r <= disc_nxt;
      sd_r[S_SQ0-1] <= '{a: a5_r, nhb: qsub('0, hb5_r),
                         en: (a5_r > 0) && !disc_nxt[CW-1]};

      for (int j = 0; j < SQRT_STEPS; j++) begin
        sq_x_r[j]   <= sq_x_nxt[j];
        sq_res_r[j] <= sq_res_nxt[j];
        sd_r[S_SQ0+j] <= sd_r[S_SQ0-1+j];
      end

      n1_r  <= qsub(sd_r[S_DIN-1].nhb, sroot);
      n2_r  <= qadd(sd_r[S_DIN-1].nhb, sroot);
      nb_r  <= qsub(cfg_cz_r, ray_r[S_DIN-1].oz);
      nt_r  <= qsub(ctop_r, ray_r[S_DIN-1].oz);
      a31_r <= sd_r[S_DIN-1].a;
      sen_r[S_DIN] <= sd_r[S_DIN-1].en;
      for (int k = S_DIN + 1; k <= S_RT + 2; k++) begin
        sen_r[k] <= sen_r[k-1];
      end

      for (int i = 0; i < 4; i++) begin
        c82_r[i] <= '{t: quo[i], px: qmul(quo[i], ray_r[S_RT].dx),
                      py: qmul(quo[i], ray_r[S_RT].dy),
                      pz: qmul(quo[i], ray_r[S_RT].dz)};
        c83_r[i] <= '{t: c82_r[i].t, px: qadd(ray_r[S_RT+1].ox, c82_r[i].px),
                      py: qadd(ray_r[S_RT+1].oy, c82_r[i].py),
                      pz: qadd(ray_r[S_RT+1].oz, c82_r[i].pz)};
        c84_r[i] <= c83_r[i];
        c85_r[i] <= c84_r[i];
        c86_r[i] <= c85_r[i];
      end

      for (int m = 0; m < 2; m++) begin
        sok84_r[m] <= sen_r[S_RT+2] && (qsub(c83_r[m].pz, cfg_cz_r) >= 0) &&
                      (qsub(c83_r[m].pz, cfg_cz_r) <= hgt_q);
        ddx84_r[m] <= qsub(c83_r[2+m].px, cfg_cx_r);
        ddy84_r[m] <= qsub(c83_r[2+m].py, cfg_cy_r);
        sok85_r[m] <= sok84_r[m];
        sqx85_r[m] <= qmul(ddx84_r[m], ddx84_r[m]);
        sqy85_r[m] <= qmul(ddy84_r[m], ddy84_r[m]);
        sok86_r[m] <= sok85_r[m];
        cok86_r[m] <= (ray_r[S_RT+4].dz != '0) &&
                      (qadd(sqx85_r[m], sqy85_r[m]) <= rr_r);
        cok87_r[m] <= cok86_r[m];
        c87_r[m]   <= c86_r[2+m];
      end

      sel87_r <= sel87_nxt;
      cl87_r  <= cl87_nxt;
      win_r[S_RT+7] <= win_nxt;
      for (int k = S_RT + 8; k <= S_NQ + 1; k++) begin
        win_r[k] <= win_r[k-1];
      end

      nnx_r <= qsub(win_r[S_RT+7].c.px, cfg_cx_r);
      nny_r <= qsub(win_r[S_RT+7].c.py, cfg_cy_r);

      mx_r  <= qmul(ray_r[S_NQ].dx, nxq);
      my_r  <= qmul(ray_r[S_NQ].dy, nyq);
      cnx_r <= unit_clamp(nxq);
      cny_r <= unit_clamp(nyq);
    end
  end

  // result stage
  logic out_hit_found_r, out_front_face_r;
  q_t   out_hit_t_r, out_point_x_r, out_point_y_r, out_point_z_r;
  nrm_t out_normal_x_r, out_normal_y_r, out_normal_z_r;
  logic hit_nxt, front_nxt;
  nrm_t nx_nxt, ny_nxt, nz_nxt;
  q_t   dot;
  q_t   dzl;
  win_t wl;

  assign wl  = win_r[S_NQ+1];
  assign dzl = ray_r[LAST-1].dz;
  assign dot = qadd(mx_r, my_r);

  always_comb begin
    hit_nxt   = 1'b1;
    front_nxt = 1'b0;
    nx_nxt    = '0;
    ny_nxt    = '0;
    nz_nxt    = '0;
    case (wl.kind)
      W_SIDE1, W_SIDE2: begin
        front_nxt = dot[CW-1];
        nx_nxt    = front_nxt ? cnx_r : -cnx_r;
        ny_nxt    = front_nxt ? cny_r : -cny_r;
      end
      W_BOT: begin
        front_nxt = !dzl[CW-1] && (dzl != '0);
        nz_nxt    = front_nxt ? -NONE : NONE;
      end
      W_TOP: begin
        front_nxt = dzl[CW-1];
        nz_nxt    = front_nxt ? NONE : -NONE;
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_found_r  <= hit_nxt;
      out_front_face_r <= front_nxt;
      out_hit_t_r      <= hit_nxt ? wl.c.t : '0;
      out_point_x_r    <= hit_nxt ? wl.c.px : '0;
      out_point_y_r    <= hit_nxt ? wl.c.py : '0;
      out_point_z_r    <= hit_nxt ? wl.c.pz : '0;
      out_normal_x_r   <= nx_nxt;
      out_normal_y_r   <= ny_nxt;
      out_normal_z_r   <= nz_nxt;
    end
  end

  assign out_hit_found  = out_hit_found_r;
  assign out_front_face = out_front_face_r;
  assign out_hit_t      = out_hit_t_r;
  assign out_point_x    = out_point_x_r;
  assign out_point_y    = out_point_y_r;
  assign out_point_z    = out_point_z_r;
  assign out_normal_x   = out_normal_x_r;
  assign out_normal_y   = out_normal_y_r;
  assign out_normal_z   = out_normal_z_r;

  `RCCI_AST_IMP(a_miss_zero, out_valid && !out_hit_found, out_hit_t == '0 && out_point_x == '0 && out_normal_z == '0 && !out_front_face, "miss result not cleared")
  `RCCI_AST_IMP(a_norm_range, out_valid, out_normal_x <= NONE && out_normal_x >= -NONE && out_normal_y <= NONE && out_normal_y >= -NONE, "normal out of unit range")
  `RCCI_AST_IMP(a_cap_normal, out_valid && out_normal_z != '0, out_hit_found && out_normal_x == '0 && out_normal_y == '0, "cap normal not axial")
  `RCCI_AST_NXT(a_hold_pipe, out_valid && out_stall, $stable(vld_r), "pipeline moved under stall")

endmodule

`default_nettype wire

@@ sim/tb_ray_capped_cylinder_intersect_top.sv @@
// testbench for ray_capped_cylinder_intersect_top: directed and random rays against several
// cylinder settings, results checked in order against a built-in fixed-point predictor
// depends on rcci_pkg and the block itself
`default_nettype none

module tb_ray_capped_cylinder_intersect_top;
  import rcci_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam longint ONE = 64'sd65536;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  typedef struct packed {
    bit        found;
    bit [31:0] t;
    bit [31:0] px;
    bit [31:0] py;
    bit [31:0] pz;
    bit [17:0] nx;
    bit [17:0] ny;
    bit [17:0] nz;
    bit        front;
  } hit_res_t;

  class cyl_scoreboard;
    longint cx = 0, cy = 0, cz = 0, rad = ONE, hgt = ONE;
    hit_res_t pending_hits[$];
    int mismatches = 0;
    int unexpected = 0;
    int checked = 0;
    int hits = 0;
    longint best;
    hit_res_t cur;

    function longint sx(bit [31:0] v);
      return longint'($signed(v));
    endfunction

    function longint sat(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
    endfunction

    function longint fmul(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return sat(p >>> 16);
      return sat(-(((-p) + (ONE - 1)) >>> 16));
    endfunction

    function longint fdiv(longint n, longint d);
      if (d == 0) return (n > 0) ? SMAX : ((n < 0) ? SMIN : 0);
      return sat((n * ONE) / d);
    endfunction

    function longint fsqrt(longint v);
      longint unsigned x, res, bt;
      if (v <= 0) return 0;
      x = longint'(v) << 16;
      res = 0;
      bt = 64'h4000_0000_0000_0000;
      while (bt > x) bt = bt >> 2;
      while (bt != 0) begin
        if (x >= res + bt) begin
          x = x - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return sat(longint'(res));
    endfunction

    function longint uclamp(longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
    endfunction

    function void set_reg(reg_idx_t idx, bit [31:0] v);
      case (idx)
        REG_CENTER_X: cx = sx(v);
        REG_CENTER_Y: cy = sx(v);
        REG_CENTER_Z: cz = sx(v);
        REG_RADIUS:   rad = longint'(v[30:0]);
        REG_HEIGHT:   hgt = longint'(v[30:0]);
        default: ;
      endcase
    endfunction

    function void take(longint t, longint p[3], longint n[3], longint d[3]);
      longint dot, c;
      bit fr;
      dot = sat(sat(fmul(d[0], n[0]) + fmul(d[1], n[1])) + fmul(d[2], n[2]));
      fr = dot < 0;
      cur.found = 1;
      cur.t = t[31:0];
      cur.px = p[0][31:0];
      cur.py = p[1][31:0];
      cur.pz = p[2][31:0];
      c = uclamp(n[0]); c = fr ? c : -c; cur.nx = c[17:0];
      c = uclamp(n[1]); c = fr ? c : -c; cur.ny = c[17:0];
      c = uclamp(n[2]); c = fr ? c : -c; cur.nz = c[17:0];
      cur.front = fr;
    endfunction

    function void side_root(longint t, longint tmin, longint o[3], longint d[3]);
      longint p[3], n[3], z;
      if (t < tmin || t >= best) return;
      for (int i = 0; i < 3; i++) p[i] = sat(o[i] + fmul(t, d[i]));
      z = sat(p[2] - cz);
      if (z < 0 || z > hgt) return;
      best = t;
      n[0] = fdiv(sat(p[0] - cx), rad);
      n[1] = fdiv(sat(p[1] - cy), rad);
      n[2] = 0;
      take(t, p, n, d);
    endfunction

    function void cap_disc(longint capz, longint nz, longint tmin, longint o[3], longint d[3]);
      longint p[3], n[3], t, ex, ey;
      t = fdiv(sat(capz - o[2]), d[2]);
      if (t < tmin || t >= best) return;
      for (int i = 0; i < 3; i++) p[i] = sat(o[i] + fmul(t, d[i]));
      ex = sat(p[0] - cx);
      ey = sat(p[1] - cy);
      if (sat(fmul(ex, ex) + fmul(ey, ey)) > fmul(rad, rad)) return;
      best = t;
      n[0] = 0;
      n[1] = 0;
      n[2] = nz;
      take(t, p, n, d);
    endfunction

    function void note_ray(ray_t r);
      longint o[3], d[3], tmin, ocx, ocy, a, hb, c, disc, s, nhb;
      o[0] = sx(r.ox); o[1] = sx(r.oy); o[2] = sx(r.oz);
      d[0] = sx(r.dx); d[1] = sx(r.dy); d[2] = sx(r.dz);
      tmin = sx(r.tmin);
      best = sx(r.tmax);
      cur = '{default: 0};
      ocx = sat(o[0] - cx);
      ocy = sat(o[1] - cy);
      a = sat(fmul(d[0], d[0]) + fmul(d[1], d[1]));
      if (a > 0) begin
        hb = sat(fmul(ocx, d[0]) + fmul(ocy, d[1]));
        c = sat(sat(fmul(ocx, ocx) + fmul(ocy, ocy)) - fmul(rad, rad));
        disc = sat(fmul(hb, hb) - fmul(a, c));
        if (disc >= 0) begin
          s = fsqrt(disc);
          nhb = sat(-hb);
          side_root(fdiv(sat(nhb - s), a), tmin, o, d);
          side_root(fdiv(sat(nhb + s), a), tmin, o, d);
        end
      end
      if (d[2] != 0) begin
        cap_disc(cz, -ONE, tmin, o, d);
        cap_disc(sat(cz + hgt), ONE, tmin, o, d);
      end
      pending_hits.insert(pending_hits.size(), cur);
    endfunction

    function void check_hit(hit_res_t got);
      hit_res_t want;
      if (pending_hits.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10) $display("unexpected result transaction");
        return;
      end
      want = pending_hits.pop_front();
      checked++;
      if (want.found) hits++;
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch #%0d exp hit=%0d t=%h p=%h %h %h n=%h %h %h ff=%0d",
                   checked, want.found, want.t, want.px, want.py, want.pz,
                   want.nx, want.ny, want.nz, want.front);
          $display("             got hit=%0d t=%h p=%h %h %h n=%h %h %h ff=%0d",
                   got.found, got.t, got.px, got.py, got.pz,
                   got.nx, got.ny, got.nz, got.front);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [CW-1:0] pwdata = '0;
  logic [CW-1:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  ray_t ray_d = '0;
  logic out_valid;
  logic out_stall = 0;
  logic out_hit_found, out_front_face;
  q_t out_hit_t, out_point_x, out_point_y, out_point_z;
  nrm_t out_normal_x, out_normal_y, out_normal_z;

  cyl_scoreboard sb = new();
  int accepted = 0;
  int quiet_cycles = 0;
  bit calm = 0;

  always #2 clk = ~clk;

  ray_capped_cylinder_intersect_top uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ray_origin_x(ray_d.ox), .in_ray_origin_y(ray_d.oy), .in_ray_origin_z(ray_d.oz),
    .in_ray_dir_x(ray_d.dx), .in_ray_dir_y(ray_d.dy), .in_ray_dir_z(ray_d.dz),
    .in_t_lower(ray_d.tmin), .in_t_upper(ray_d.tmax),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit_found(out_hit_found), .out_hit_t(out_hit_t),
    .out_point_x(out_point_x), .out_point_y(out_point_y), .out_point_z(out_point_z),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y), .out_normal_z(out_normal_z),
    .out_front_face(out_front_face)
  );

  always @(negedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 15);

  always @(posedge clk) begin
    hit_res_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_ray(ray_d);
        accepted++;
      end
      if (out_valid && !out_stall) begin
        got.found = out_hit_found;
        got.t = out_hit_t;
        got.px = out_point_x;
        got.py = out_point_y;
        got.pz = out_point_z;
        got.nx = out_normal_x;
        got.ny = out_normal_y;
        got.nz = out_normal_z;
        got.front = out_front_face;
        sb.check_hit(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", sb.pending_hits.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_ray(input ray_t r);
    int seen;
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    ray_d <= r;
    in_valid <= 1'b1;
    seen = accepted;
    @(negedge clk);
    while (accepted == seen) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_hits.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input bit [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(4 * int'(idx));
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic set_cylinder(input bit [31:0] x, input bit [31:0] y, input bit [31:0] z,
                              input bit [31:0] r, input bit [31:0] h);
    drain();
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_CENTER_Z, z);
    write_reg(REG_RADIUS, r);
    write_reg(REG_HEIGHT, h);
  endtask

  function automatic ray_t mk(longint ox, longint oy, longint oz, longint dx, longint dy,
                              longint dz, longint tl, longint tu);
    ray_t r;
    r.ox = ox[31:0]; r.oy = oy[31:0]; r.oz = oz[31:0];
    r.dx = dx[31:0]; r.dy = dy[31:0]; r.dz = dz[31:0];
    r.tmin = tl[31:0]; r.tmax = tu[31:0];
    return r;
  endfunction

  function automatic longint spread(longint span);
    longint v;
    v = longint'($urandom()) % (2 * span + 1);
    return v - span;
  endfunction

  function automatic ray_t aimed_ray();
    longint span, tx, ty, tz, ox, oy, oz, dx, dy, dz, tl, tu;
    int k;
    span = (sb.rad > 0 && sb.rad < 64'sd16777216) ? sb.rad : ONE;
    tx = sb.cx + spread(span);
    ty = sb.cy + spread(span);
    tz = sb.cz + ((sb.hgt > 0 && sb.hgt < 64'sd16777216) ? spread(sb.hgt) : spread(ONE));
    ox = tx + spread(4 * span);
    oy = ty + spread(4 * span);
    oz = tz + spread(4 * span);
    case ($urandom_range(0, 5))
      0: ox = tx;
      1: begin ox = tx; oy = ty; end
      2: oz = tz;
      default: ;
    endcase
    k = $urandom_range(0, 3);
    dx = (tx - ox) >>> k;
    dy = (ty - oy) >>> k;
    dz = (tz - oz) >>> k;
    tl = ($urandom_range(0, 3) == 0) ? spread(4 * ONE) : 0;
    tu = ($urandom_range(0, 2) == 0) ? spread(64'sd1048576) : SMAX;
    return mk(ox, oy, oz, dx, dy, dz, tl, tu);
  endfunction

  function automatic ray_t noise_ray();
    return mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom());
  endfunction

  task automatic random_rays(input int count);
    for (int i = 0; i < count; i++)
      send_ray(($urandom_range(0, 99) < 75) ? aimed_ray() : noise_ray());
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default unit cylinder at the origin
    send_ray(mk(-3 * ONE, 0, ONE / 2, ONE, 0, 0, 0, SMAX));
    send_ray(mk(0, 0, ONE / 2, ONE, 0, 0, 0, SMAX));
    send_ray(mk(0, 0, ONE / 2, ONE, 0, 0, -4 * ONE, SMAX));
    send_ray(mk(0, 0, 3 * ONE, 0, 0, -ONE, 0, SMAX));
    send_ray(mk(ONE / 5, ONE / 10, -2 * ONE, 0, 0, ONE, 0, SMAX));
    send_ray(mk(0, 0, ONE / 2, 0, 0, ONE, 0, SMAX));
    send_ray(mk(-3 * ONE, 5 * ONE, ONE / 2, ONE, 0, 0, 0, SMAX));
    send_ray(mk(-3 * ONE, 0, ONE / 2, ONE, 0, 0, ONE, ONE));
    send_ray(mk(-3 * ONE, 0, ONE / 2, ONE, 0, 0, 2 * ONE, ONE));
    send_ray(mk(-3 * ONE, 0, ONE / 2, ONE, 0, 0, 0, 2 * ONE));
    send_ray(mk(-2 * ONE, ONE / 3, 2 * ONE, ONE, 0, -ONE, 0, SMAX));
    send_ray(mk(-2 * ONE, -2 * ONE, -ONE, ONE, ONE, ONE, 0, SMAX));
    send_ray(mk(3 * ONE, 0, 5 * ONE, -ONE, 0, 0, 0, SMAX));
    send_ray(mk(0, 0, 0, 0, 0, 0, 0, SMAX));
    send_ray(mk(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX));
    send_ray(mk(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN));
    send_ray(mk(SMIN, 0, ONE / 2, SMAX, 0, 0, SMIN, SMAX));
    send_ray(mk(0, 0, SMAX, 0, 0, SMIN, SMIN, SMAX));
    send_ray(mk(ONE, 0, ONE / 2, 0, ONE, 0, SMIN, SMAX));
    random_rays(90);

    set_cylinder(32'h0003_8000, 32'hfffe_4000, 32'hffff_0000, 32'h0002_0000, 32'h0004_0000);
    random_rays(100);

    calm = 1;
    set_cylinder(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
    random_rays(90);
    calm = 0;

    set_cylinder(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    random_rays(90);

    // bit 31 is dropped by the 31-bit radius, leaving a zero radius
    set_cylinder(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_ray(mk(SMAX, SMIN, 0, 0, 0, ONE, SMIN, SMAX));
    send_ray(mk(0, 0, 0, ONE, ONE, ONE, SMIN, SMAX));
    random_rays(80);

    set_cylinder($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    random_rays(80);

    set_cylinder(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
    random_rays(100);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d rays checked over seven cylinder settings, %0d of them hits", sb.checked,
             sb.hits);
    $display("%0d mismatches, %0d unexpected, %0d outstanding", sb.mismatches, sb.unexpected,
             sb.pending_hits.size());
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
